// ----- rtl/sprite_quad_vertex_expander_assert.svh -----
// assertion macros for the sprite quad vertex expander
`ifndef SPRITE_QUAD_VERTEX_EXPANDER_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_EXPANDER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SQVE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SQVE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// implication after a fixed number of cycles
`define SQVE_ASSERT_DLY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("assertion failed");

`else

`define SQVE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SQVE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`define SQVE_ASSERT_DLY(label, clk, rst_n, ante, n, cons)

`endif

`endif

// ----- rtl/sqve_pkg.sv -----
// types, constants and corner tables for the sprite quad vertex expander
package sqve_pkg;

    localparam int VERTS_PER_QUAD = 6;
    localparam int NUM_COMP       = 3;
    localparam int COMP_W         = 20;
    localparam int REG_W          = COMP_W * NUM_COMP;

    // register indexes
    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_UP     = 2'd2;
    localparam logic [1:0] REG_ORIENT = 2'd3;

    // quarter-turn codes, orientation bits 1:0
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [2:0] LAST_VERT = 3'(VERTS_PER_QUAD - 1);

    localparam logic signed [37:0] POS_MAX = 38'sd524287;
    localparam logic signed [37:0] POS_MIN = -38'sd524288;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [COMP_W:0]   basis_t;   // one bit more, holds the negated minimum

    // corner selects per vertex: h=1 picks the right edge, v=1 the top edge
    typedef struct packed {
        logic h;
        logic v;
    } corner_t;

    function automatic corner_t vertex_corner(input logic [2:0] k);
        corner_t c;
        case (k)
            3'd0:    c = '{h: 1'b0, v: 1'b0};
            3'd1:    c = '{h: 1'b1, v: 1'b0};
            3'd2:    c = '{h: 1'b0, v: 1'b1};
            3'd3:    c = '{h: 1'b0, v: 1'b1};
            3'd4:    c = '{h: 1'b1, v: 1'b0};
            3'd5:    c = '{h: 1'b1, v: 1'b1};
            default: c = '{h: 1'b0, v: 1'b0};
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/sprite_quad_vertex_expander.sv -----
// sprite quad vertex expander: one sprite part in, six textured vertices out
//
// usage
//   configuration: write base_position, right_vector, up_vector and
//   orientation_code through wr_en / wr_index / wr_data while the block is idle
//   input: a part beat is taken at a rising edge where start is high and busy
//   is low; busy stays high after a take until the part issues its last vertex,
//   so a new part can be taken in the cycle its predecessor issues vertex five
//   output: each vertex is on the result ports for one cycle with strobe high;
//   the receiver cannot hold results off, so there is no stall path
//   flow: after the take, each vertex passes the corner select, product, sum
//   and combine registers and then the output register; back-to-back parts
//   give one vertex every cycle, the single vertex-wide datapath seeing one
//   vertex per cycle
//   pipeline: issue (part register, vertex counter), corner select and basis
//   rotation, multiply, origin/extent sums, combine and round, saturate
//   reset: rst_n clears the configuration registers, vertex counter and valid
//   bits to zero and empties the pipeline; vertices in flight are dropped
module sprite_quad_vertex_expander
    import sqve_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [REG_W-1:0]    wr_data,

    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  offset_right,
    input  logic signed [15:0]  offset_up,
    input  logic [11:0]         tex_left,
    input  logic [11:0]         tex_top,
    input  logic [11:0]         tex_width,
    input  logic [11:0]         tex_height,
    input  logic signed [12:0]  anchor_x,
    input  logic signed [12:0]  anchor_y,
    input  logic                last_part,

    output logic                strobe,
    output logic [12:0]         tex_u,
    output logic [12:0]         tex_v,
    output logic signed [19:0]  vert_x,
    output logic signed [19:0]  vert_y,
    output logic signed [19:0]  vert_z,
    output logic                last_vertex,
    output logic                batch_end
);

`include "sprite_quad_vertex_expander_assert.svh"

    // ---------------- configuration registers ----------------
    logic [REG_W-1:0] base_reg;
    logic [REG_W-1:0] right_reg;
    logic [REG_W-1:0] up_reg;
    logic [2:0]       orient_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            right_reg  <= '0;
            up_reg     <= '0;
            orient_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BASE:   base_reg   <= wr_data;
                REG_RIGHT:  right_reg  <= wr_data;
                REG_UP:     up_reg     <= wr_data;
                REG_ORIENT: orient_reg <= wr_data[2:0];
                default:    ;
            endcase
        end
    end

    // per-component views of the configuration
    comp_t  base_c  [NUM_COMP];
    comp_t  right_c [NUM_COMP];
    comp_t  up_c    [NUM_COMP];
    basis_t nr_c    [NUM_COMP];   // rotated right
    basis_t nu_c    [NUM_COMP];   // rotated up

    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++)
        begin
            basis_t r21;
            basis_t u21;
            basis_t u2;
            base_c[c]  = base_reg[c*COMP_W +: COMP_W];
            right_c[c] = right_reg[c*COMP_W +: COMP_W];
            up_c[c]    = up_reg[c*COMP_W +: COMP_W];
            r21 = basis_t'(right_c[c]);
            u21 = basis_t'(up_c[c]);
            // mirror flips up before the rotation
            u2  = orient_reg[2] ? -u21 : u21;
            case (orient_reg[1:0])
                ROT_0:
                begin
                    nr_c[c] = r21;
                    nu_c[c] = u2;
                end
                ROT_90:
                begin
                    nr_c[c] = u2;
                    nu_c[c] = -r21;
                end
                ROT_180:
                begin
                    nr_c[c] = -r21;
                    nu_c[c] = -u2;
                end
                ROT_270:
                begin
                    nr_c[c] = -u2;
                    nu_c[c] = r21;
                end
                default:
                begin
                    nr_c[c] = r21;
                    nu_c[c] = u2;
                end
            endcase
        end
    end

    // ---------------- issue stage: part register and vertex counter ----------------
    logic               active_reg;
    logic [2:0]         cnt_reg;
    logic               accept;

    logic signed [15:0] offr0_reg;
    logic signed [15:0] offu0_reg;
    logic [11:0]        tl0_reg;
    logic [11:0]        tt0_reg;
    logic [11:0]        tw0_reg;
    logic [11:0]        th0_reg;
    logic signed [12:0] ax0_reg;
    logic signed [12:0] ay0_reg;
    logic               last0_reg;

    // free in the cycle the last vertex of the current part issues
    assign busy   = active_reg && (cnt_reg != LAST_VERT);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (accept)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (active_reg)
        begin
            if (cnt_reg == LAST_VERT)
            begin
                active_reg <= 1'b0;
                cnt_reg    <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            offr0_reg <= offset_right;
            offu0_reg <= offset_up;
            tl0_reg   <= tex_left;
            tt0_reg   <= tex_top;
            tw0_reg   <= tex_width;
            th0_reg   <= tex_height;
            ax0_reg   <= anchor_x;
            ay0_reg   <= anchor_y;
            last0_reg <= last_part;
        end
    end

    // ---------------- stage 1: corner select ----------------
    corner_t            corner;
    logic signed [13:0] ex_next;
    logic signed [13:0] ey_next;
    logic [12:0]        tu_next;
    logic [12:0]        tv_next;

    always_comb
    begin
        corner  = vertex_corner(cnt_reg);
        ex_next = corner.h ? ($signed({2'b00, tw0_reg}) - 14'(ax0_reg)) : -14'(ax0_reg);
        ey_next = corner.v ? 14'(ay0_reg) : (14'(ay0_reg) - $signed({2'b00, th0_reg}));
        tu_next = corner.h ? ({1'b0, tl0_reg} + {1'b0, tw0_reg}) : {1'b0, tl0_reg};
        tv_next = corner.v ? {1'b0, tt0_reg} : ({1'b0, tt0_reg} + {1'b0, th0_reg});
    end

    logic               v1_reg;
    logic signed [13:0] ex1_reg;
    logic signed [13:0] ey1_reg;
    logic signed [15:0] offr1_reg;
    logic signed [15:0] offu1_reg;
    logic [12:0]        tu1_reg;
    logic [12:0]        tv1_reg;
    logic               lv1_reg;
    logic               be1_reg;
    basis_t             nr1_reg [NUM_COMP];
    basis_t             nu1_reg [NUM_COMP];

    always_ff @(posedge clk)
    begin
        ex1_reg   <= ex_next;
        ey1_reg   <= ey_next;
        offr1_reg <= offr0_reg;
        offu1_reg <= offu0_reg;
        tu1_reg   <= tu_next;
        tv1_reg   <= tv_next;
        lv1_reg   <= (cnt_reg == LAST_VERT);
        be1_reg   <= (cnt_reg == LAST_VERT) && last0_reg;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            nr1_reg[c] <= nr_c[c];
            nu1_reg[c] <= nu_c[c];
        end
    end

    // ---------------- stage 2: products ----------------
    logic               v2_reg;
    logic [12:0]        tu2_reg;
    logic [12:0]        tv2_reg;
    logic               lv2_reg;
    logic               be2_reg;
    logic signed [35:0] p_or2_reg [NUM_COMP];   // offset_right * right
    logic signed [35:0] p_ou2_reg [NUM_COMP];   // offset_up * up
    logic signed [34:0] p_ex2_reg [NUM_COMP];   // ex * rotated right
    logic signed [34:0] p_ey2_reg [NUM_COMP];   // ey * rotated up

    always_ff @(posedge clk)
    begin
        tu2_reg <= tu1_reg;
        tv2_reg <= tv1_reg;
        lv2_reg <= lv1_reg;
        be2_reg <= be1_reg;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            p_or2_reg[c] <= 36'(offr1_reg) * 36'(right_c[c]);
            p_ou2_reg[c] <= 36'(offu1_reg) * 36'(up_c[c]);
            p_ex2_reg[c] <= 35'(ex1_reg) * 35'(nr1_reg[c]);
            p_ey2_reg[c] <= 35'(ey1_reg) * 35'(nu1_reg[c]);
        end
    end

    // ---------------- stage 3: origin and extent sums, Q.8 and Q.0 ----------------
    logic               v3_reg;
    logic [12:0]        tu3_reg;
    logic [12:0]        tv3_reg;
    logic               lv3_reg;
    logic               be3_reg;
    logic signed [37:0] org3_reg [NUM_COMP];
    logic signed [35:0] ext3_reg [NUM_COMP];

    always_ff @(posedge clk)
    begin
        tu3_reg <= tu2_reg;
        tv3_reg <= tv2_reg;
        lv3_reg <= lv2_reg;
        be3_reg <= be2_reg;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            org3_reg[c] <= ($signed({38'(base_c[c])}) <<< 8) + 38'(p_or2_reg[c])
                           + 38'(p_ou2_reg[c]);
            ext3_reg[c] <= 36'(p_ex2_reg[c]) + 36'(p_ey2_reg[c]);
        end
    end

    // ---------------- stage 4: combine and add the rounding half ----------------
    logic               v4_reg;
    logic [12:0]        tu4_reg;
    logic [12:0]        tv4_reg;
    logic               lv4_reg;
    logic               be4_reg;
    logic signed [45:0] sum4_reg [NUM_COMP];

    always_ff @(posedge clk)
    begin
        tu4_reg <= tu3_reg;
        tv4_reg <= tv3_reg;
        lv4_reg <= lv3_reg;
        be4_reg <= be3_reg;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            sum4_reg[c] <= 46'(org3_reg[c]) + (46'(ext3_reg[c]) <<< 8) + 46'sd128;
        end
    end

    // ---------------- stage 5: drop fraction and saturate ----------------
    comp_t pos_next [NUM_COMP];

    always_comb
    begin
        for (int c = 0; c < NUM_COMP; c++)
        begin
            logic signed [37:0] q8;
            q8 = sum4_reg[c][45:8];   // floor after the half, so ties go up
            if (q8 > POS_MAX)
            begin
                pos_next[c] = POS_MAX[COMP_W-1:0];
            end
            else if (q8 < POS_MIN)
            begin
                pos_next[c] = POS_MIN[COMP_W-1:0];
            end
            else
            begin
                pos_next[c] = q8[COMP_W-1:0];
            end
        end
    end

    logic v5_reg;

    always_ff @(posedge clk)
    begin
        tex_u       <= tu4_reg;
        tex_v       <= tv4_reg;
        vert_x      <= pos_next[0];
        vert_y      <= pos_next[1];
        vert_z      <= pos_next[2];
        last_vertex <= lv4_reg;
        batch_end   <= be4_reg;
    end

    // valid bits travel with each vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= active_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign strobe = v5_reg;

    // ---------------- checks ----------------
    `SQVE_ASSERT_NXT(a_busy_after_take, clk, rst_n, accept, busy)
    `SQVE_ASSERT_NXT(a_count_steps, clk, rst_n,
        active_reg && !accept && (cnt_reg != LAST_VERT),
        active_reg && (cnt_reg == $past(cnt_reg) + 3'd1))
    `SQVE_ASSERT_DLY(a_vertex_reaches_output, clk, rst_n, v1_reg, 4, strobe)
    `SQVE_ASSERT_IMP(a_batch_end_on_last, clk, rst_n, strobe && batch_end, last_vertex)

endmodule
